// ===== hw/rtl/ethrx_pkg.sv =====
// Shared constants, types and codes for the Ethernet receive FCS trimmer.
package ethrx_pkg;

  localparam int MAX_FRAME_DEF = 2048;

  localparam int LEN_W = 12;
  localparam int KIND_W = 3;
  localparam int MAC_W = 48;

  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_RESIDUE = 32'h2144_DF1C;

  localparam int MIN_FRAME_NOFCS = 60;
  localparam int FCS_BYTES = 4;
  localparam int HDR_BYTES = 14;
  localparam int SRC_BYTES = 6;
  localparam int ARP_FIXED = 8;

  localparam int POS_SRC = 6;
  localparam int POS_ETYPE_HI = 12;
  localparam int POS_ETYPE_LO = 13;
  localparam int POS_IPLEN_HI = 16;
  localparam int POS_IPLEN_LO = 17;
  localparam int POS_ARP_HLEN = 18;
  localparam int POS_ARP_PLEN = 19;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP = 16'h0806;

  typedef enum logic [KIND_W-1:0] {
    KIND_HOST = 3'd0,
    KIND_IPV4 = 3'd1,
    KIND_ARP = 3'd2,
    KIND_FCS_STRIP = 3'd3,
    KIND_NO_FCS = 3'd4
  } trim_kind_t;

  typedef struct packed {
    logic src_match;
    logic [15:0] ether_type;
    logic [15:0] ip_total_length;
    logic [7:0] arp_hw_len;
    logic [7:0] arp_proto_len;
    logic crc_good;
  } hdr_info_t;

endpackage

// ===== hw/rtl/ethernet_rx_fcs_trimmer.sv =====
// Top level of the Ethernet receive FCS trimmer: handshakes, byte and result registers.
//
//   Port group  Dir  Handshake        Payload
//   in_*        in   in_valid/stall   data_byte, last_byte
//   out_*       out  out_valid/stall  frame_length, trim_kind
//   cfg_*       in   cfg_valid/ready  host_mac
//
// One byte is taken every cycle unless in_stall is high; the result of a frame passes
// from the byte register to the result register, as the byte register feeds it directly.
// Reset is synchronous and active low; it clears the frame state and host_mac.
// The input stalls only when a last byte waits in the byte register while the
// result register holds a result that is itself stalled.
module ethernet_rx_fcs_trimmer #(
  parameter int MAX_FRAME = ethrx_pkg::MAX_FRAME_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ethrx_pkg::LEN_W-1:0] out_frame_length,
  output logic [ethrx_pkg::KIND_W-1:0] out_trim_kind,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ethrx_pkg::MAC_W-1:0] cfg_host_mac
);
  import ethrx_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  logic s1_valid_r;
  logic [7:0] s1_data_r;
  logic s1_last_r;
  logic s1_go;
  logic [MAC_W-1:0] host_mac_r;
  logic out_valid_r;
  logic [LEN_W-1:0] out_len_r;
  trim_kind_t out_kind_r;

  logic [CNT_W-1:0] size;
  hdr_info_t info;
  logic [LEN_W-1:0] fit_len;
  trim_kind_t fit_kind;

  assign in_stall = s1_valid_r && s1_last_r && out_valid_r && out_stall;
  assign s1_go = s1_valid_r && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_frame_length = out_len_r;
  assign out_trim_kind = out_kind_r;

  ethrx_hdr_parse #(
    .MAX_FRAME(MAX_FRAME),
    .CNT_W(CNT_W)
  ) u_parse (
    .clk(clk),
    .rst_n(rst_n),
    .step(s1_go),
    .data_byte(s1_data_r),
    .last_byte(s1_last_r),
    .host_mac(host_mac_r),
    .size(size),
    .info(info)
  );

  ethrx_len_fit #(
    .MAX_FRAME(MAX_FRAME),
    .CNT_W(CNT_W)
  ) u_fit (
    .size(size),
    .info(info),
    .frame_length(fit_len),
    .trim_kind(fit_kind)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      host_mac_r <= '0;
    end else begin
      s1_valid_r <= in_stall ? 1'b1 : in_valid;
      if (s1_go && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        host_mac_r <= cfg_host_mac;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_go && s1_last_r) begin
      out_len_r <= fit_len;
      out_kind_r <= fit_kind;
    end
  end

endmodule

// ===== hw/rtl/ethrx_hdr_parse.sv =====
// Per-frame header capture, source MAC compare, byte count and CRC-32 update.
module ethrx_hdr_parse #(
  parameter int MAX_FRAME = ethrx_pkg::MAX_FRAME_DEF,
  parameter int CNT_W = $clog2(MAX_FRAME + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  input  logic [ethrx_pkg::MAC_W-1:0] host_mac,
  output logic [CNT_W-1:0]            size,
  output ethrx_pkg::hdr_info_t        info
);
  import ethrx_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic src_match_r, src_match_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [15:0] ip_len_r, ip_len_nxt;
  logic [7:0] arp_hlen_r, arp_hlen_nxt;
  logic [7:0] arp_plen_r, arp_plen_nxt;
  logic in_src;
  logic [7:0] src_byte;

  function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  always_comb begin
    in_src = 1'b0;
    src_byte = 8'd0;
    for (int k = 0; k < SRC_BYTES; k++) begin
      if (count_r == CNT_W'(POS_SRC + k)) begin
        in_src = 1'b1;
        src_byte = host_mac[MAC_W-1-8*k -: 8];
      end
    end
  end

  always_comb begin
    src_match_nxt = src_match_r & ~(in_src & (src_byte != data_byte));
    etype_nxt = etype_r;
    ip_len_nxt = ip_len_r;
    arp_hlen_nxt = arp_hlen_r;
    arp_plen_nxt = arp_plen_r;
    if (count_r == CNT_W'(POS_ETYPE_HI)) etype_nxt[15:8] = data_byte;
    if (count_r == CNT_W'(POS_ETYPE_LO)) etype_nxt[7:0] = data_byte;
    if (count_r == CNT_W'(POS_IPLEN_HI)) ip_len_nxt[15:8] = data_byte;
    if (count_r == CNT_W'(POS_IPLEN_LO)) ip_len_nxt[7:0] = data_byte;
    if (count_r == CNT_W'(POS_ARP_HLEN)) arp_hlen_nxt = data_byte;
    if (count_r == CNT_W'(POS_ARP_PLEN)) arp_plen_nxt = data_byte;
    crc_nxt = crc_step(crc_r, data_byte);
    count_nxt = (count_r < CNT_W'(MAX_FRAME)) ? count_r + CNT_W'(1) : count_r;
  end

  assign size = count_nxt;
  assign info.src_match = src_match_nxt;
  assign info.ether_type = etype_nxt;
  assign info.ip_total_length = ip_len_nxt;
  assign info.arp_hw_len = arp_hlen_nxt;
  assign info.arp_proto_len = arp_plen_nxt;
  assign info.crc_good = (~crc_nxt) == CRC_RESIDUE;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      count_r <= '0;
      crc_r <= CRC_PRESET;
      src_match_r <= 1'b1;
      etype_r <= '0;
      ip_len_r <= '0;
      arp_hlen_r <= '0;
      arp_plen_r <= '0;
    end else if (step) begin
      count_r <= count_nxt;
      crc_r <= crc_nxt;
      src_match_r <= src_match_nxt;
      etype_r <= etype_nxt;
      ip_len_r <= ip_len_nxt;
      arp_hlen_r <= arp_hlen_nxt;
      arp_plen_r <= arp_plen_nxt;
    end
  end

endmodule

// ===== hw/rtl/ethrx_len_fit.sv =====
// Frame classification and corrected length calculation at frame end.
module ethrx_len_fit #(
  parameter int MAX_FRAME = ethrx_pkg::MAX_FRAME_DEF,
  parameter int CNT_W = $clog2(MAX_FRAME + 1)
) (
  input  logic [CNT_W-1:0]             size,
  input  ethrx_pkg::hdr_info_t         info,
  output logic [ethrx_pkg::LEN_W-1:0]  frame_length,
  output ethrx_pkg::trim_kind_t        trim_kind
);
  import ethrx_pkg::*;

  localparam int PAY_W = (CNT_W > 16) ? CNT_W : 16;
  localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  logic has_type, is_host, is_ipv4, is_arp;
  logic [CNT_W-1:0] cap;
  logic [10:0] arp_pay;
  logic [PAY_W-1:0] pay, pay_floor, pay_fit;
  logic [CNT_W-1:0] len;
  logic [EXT_W-1:0] len_ext;

  always_comb begin
    has_type = size >= CNT_W'(HDR_BYTES);
    is_host = info.src_match && (size >= CNT_W'(2 * SRC_BYTES));
    is_ipv4 = has_type && (info.ether_type == ETYPE_IPV4);
    is_arp = has_type && (info.ether_type == ETYPE_ARP);
    cap = (size > CNT_W'(HDR_BYTES)) ? size - CNT_W'(HDR_BYTES) : '0;
    arp_pay = 11'(ARP_FIXED) + {2'b00, info.arp_hw_len, 1'b0}
            + {2'b00, info.arp_proto_len, 1'b0};
    pay = is_ipv4 ? PAY_W'(info.ip_total_length) : PAY_W'(arp_pay);
    pay_floor = (pay < PAY_W'(MIN_FRAME_NOFCS - HDR_BYTES))
              ? PAY_W'(MIN_FRAME_NOFCS - HDR_BYTES) : pay;
    pay_fit = (pay_floor > PAY_W'(cap)) ? PAY_W'(cap) : pay_floor;

    if (is_host) begin
      len = size;
      trim_kind = KIND_HOST;
    end else if (is_ipv4 || is_arp) begin
      len = CNT_W'(pay_fit) + CNT_W'(HDR_BYTES);
      trim_kind = is_ipv4 ? KIND_IPV4 : KIND_ARP;
    end else if (info.crc_good) begin
      len = (size >= CNT_W'(FCS_BYTES)) ? size - CNT_W'(FCS_BYTES) : '0;
      trim_kind = KIND_FCS_STRIP;
    end else begin
      len = size;
      trim_kind = KIND_NO_FCS;
    end
    len_ext = EXT_W'(len);
    frame_length = len_ext[LEN_W-1:0];
  end

endmodule
